// File: rtl/owned_byte_fifo_with_flush_mark_assert.svh
// Assertion macros for the owned byte FIFO.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef OWNED_BYTE_FIFO_WITH_FLUSH_MARK_ASSERT_SVH
`define OWNED_BYTE_FIFO_WITH_FLUSH_MARK_ASSERT_SVH

// Same-cycle implication.
`define OBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/obfifo_pkg.sv
`default_nettype none

package obfifo_pkg;

  localparam int DATA_W = 8;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 32;

  // Operation codes on in_func; six and seven are no-ops.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH      = 3'd0,
    FN_POP       = 3'd1,
    FN_QUERY     = 3'd2,
    FN_ADOPT     = 3'd3,
    FN_CLOSE     = 3'd4,
    FN_TAKE_LOST = 3'd5
  } func_t;

  typedef enum logic {
    S_IDLE,
    S_RDATA
  } fsm_t;

endpackage

`default_nettype wire

// File: rtl/owned_byte_fifo_with_flush_mark.sv
// Byte ring buffer owned by one client at a time. Every transfer on the input
// channel gives exactly one result transfer. A push from a client other than the
// owner adopts that client first (close request for the previous owner, flush mark
// at the current write pointer, lost flag set); the byte is then stored, or
// counted as dropped when DEPTH-1 bytes are already held. Pop and level query apply
// a pending flush first, discarding and counting everything up to the mark.
// An item is accepted in S_IDLE; in S_RDATA the input stalls while the ring memory's
// registered read port delivers, so no new item is taken before the last result is
// ready. The next item is taken while a result still waits, as long as the output
// register is free or being emptied at that edge. The ring memory has no reset and
// no clearing pass; it is only read at entries that a push has written.
`default_nettype none

`include "owned_byte_fifo_with_flush_mark_assert.svh"

module owned_byte_fifo_with_flush_mark
  import obfifo_pkg::*;
#(
  parameter int DEPTH   = 1024,  // ring entries, holds at most DEPTH-1 bytes
  parameter int ID_BITS = 6      // client socket number width
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [FUNC_W-1:0]         in_func,
  input  wire logic [ID_BITS-1:0]        in_client_id,
  input  wire logic [DATA_W-1:0]         in_data_in,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [DATA_W-1:0]              out_read_data,
  output logic                           out_read_valid,
  output logic [$clog2(DEPTH)-1:0]       out_fill_level,
  output logic                           out_client_lost,
  output logic                           out_close_valid,
  output logic [ID_BITS-1:0]             out_close_id,
  output logic [STAT_W-1:0]              out_handshakes,
  output logic [STAT_W-1:0]              out_bytes_received,
  output logic [STAT_W-1:0]              out_bytes_dropped,
  output logic [STAT_W-1:0]              out_bytes_flushed
);

  localparam int                 PTR_W    = $clog2(DEPTH);
  localparam logic [PTR_W:0]     DEPTH_W  = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W-1:0]   LAST_IDX = PTR_W'(DEPTH - 1);

  // Pointer helpers; DEPTH need not be a power of two.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] to_p,
                                                 input logic [PTR_W-1:0] from_p);
    logic [PTR_W:0] d;
    d = {1'b0, to_p} - {1'b0, from_p};
    if (to_p < from_p) begin
      d = d + DEPTH_W;
    end
    ring_dist = d[PTR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsm_t                state_r, state_nxt;

  logic [PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [PTR_W-1:0]    rptr_r, rptr_nxt;
  logic [PTR_W-1:0]    flush_mark_r, flush_mark_nxt;
  logic                flush_pend_r, flush_pend_nxt;
  logic [ID_BITS-1:0]  owner_id_r, owner_id_nxt;
  logic                owner_valid_r, owner_valid_nxt;
  logic                lost_r, lost_nxt;

  logic [STAT_W-1:0]   hs_cnt_r, hs_cnt_nxt;
  logic [STAT_W-1:0]   rcv_cnt_r, rcv_cnt_nxt;
  logic [STAT_W-1:0]   drop_cnt_r, drop_cnt_nxt;
  logic [STAT_W-1:0]   flush_cnt_r, flush_cnt_nxt;

  // Result register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_read_data_r;
  logic                out_read_valid_r;
  logic                out_client_lost_r;
  logic                out_close_valid_r;
  logic [ID_BITS-1:0]  out_close_id_r;

  // Ring memory, one write port and one registered read port
  logic [DATA_W-1:0]   ring_mem [DEPTH];
  logic [DATA_W-1:0]   mem_q_r;
  logic                mem_we;
  logic                mem_re;

  logic                in_xfer;
  logic                rdata_load;
  logic [PTR_W-1:0]    eff_rptr;
  logic [PTR_W-1:0]    wptr_inc;
  logic                adopt_req;
  logic                owner_match;
  logic                rvalid;
  logic                close_v;
  logic                lost_out;

  assign in_xfer     = in_valid && !in_stall;
  assign eff_rptr    = flush_pend_r ? flush_mark_r : rptr_r;
  assign wptr_inc    = ring_next(wptr_r);
  assign owner_match = owner_valid_r && (owner_id_r == in_client_id);

  // ---------------------------------------------------------------------------
  // Sequencer: accept in S_IDLE, then S_RDATA for the memory read
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = in_xfer ? S_RDATA : S_IDLE;
      S_RDATA: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      S_IDLE: begin
        // free slot at the next edge: empty now, or the waiting result leaves now
        in_stall   = out_valid_r && out_stall;
        rdata_load = 1'b0;
      end
      S_RDATA: begin
        in_stall   = 1'b1;
        rdata_load = 1'b1;
      end
      default: begin
        in_stall   = 1'b1;
        rdata_load = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-item update, committed on the accept edge
  // ---------------------------------------------------------------------------
  always_comb begin
    wptr_nxt        = wptr_r;
    rptr_nxt        = rptr_r;
    flush_mark_nxt  = flush_mark_r;
    flush_pend_nxt  = flush_pend_r;
    owner_id_nxt    = owner_id_r;
    owner_valid_nxt = owner_valid_r;
    lost_out        = lost_r;
    hs_cnt_nxt      = hs_cnt_r;
    rcv_cnt_nxt     = rcv_cnt_r;
    drop_cnt_nxt    = drop_cnt_r;
    flush_cnt_nxt   = flush_cnt_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    rvalid          = 1'b0;
    close_v         = 1'b0;
    adopt_req       = 1'b0;

    case (func_t'(in_func))
      FN_PUSH: begin
        adopt_req = !owner_match;
        // fullness is judged against the unflushed read pointer
        if (wptr_inc != rptr_r) begin
          mem_we      = 1'b1;
          wptr_nxt    = wptr_inc;
          rcv_cnt_nxt = rcv_cnt_r + 1'b1;
        end else begin
          drop_cnt_nxt = drop_cnt_r + 1'b1;
        end
      end
      FN_POP, FN_QUERY: begin
        if (flush_pend_r) begin
          flush_pend_nxt = 1'b0;
          flush_cnt_nxt  = flush_cnt_r +
                           {{(STAT_W-PTR_W){1'b0}}, ring_dist(flush_mark_r, rptr_r)};
        end
        rptr_nxt = eff_rptr;
        if ((func_t'(in_func) == FN_POP) && (wptr_r != eff_rptr)) begin
          mem_re   = 1'b1;
          rvalid   = 1'b1;
          rptr_nxt = ring_next(eff_rptr);
        end
      end
      FN_ADOPT: begin
        adopt_req = 1'b1;
      end
      FN_CLOSE: begin
        if (owner_match) begin
          owner_valid_nxt = 1'b0;
          lost_out        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (adopt_req) begin
      hs_cnt_nxt      = hs_cnt_r + 1'b1;
      close_v         = owner_valid_r && (owner_id_r != in_client_id);
      owner_id_nxt    = in_client_id;
      owner_valid_nxt = 1'b1;
      flush_mark_nxt  = wptr_r;  // mark taken before this push's byte lands
      flush_pend_nxt  = 1'b1;
      lost_out        = 1'b1;
    end

    // take-lost reports the flag, then clears it
    lost_nxt = (func_t'(in_func) == FN_TAKE_LOST) ? 1'b0 : lost_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wptr_r        <= '0;
      rptr_r        <= '0;
      flush_mark_r  <= '0;
      flush_pend_r  <= 1'b0;
      owner_id_r    <= '0;
      owner_valid_r <= 1'b0;
      lost_r        <= 1'b0;
      hs_cnt_r      <= '0;
      rcv_cnt_r     <= '0;
      drop_cnt_r    <= '0;
      flush_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= rdata_load || (out_valid_r && out_stall);
      if (in_xfer) begin
        wptr_r        <= wptr_nxt;
        rptr_r        <= rptr_nxt;
        flush_mark_r  <= flush_mark_nxt;
        flush_pend_r  <= flush_pend_nxt;
        owner_id_r    <= owner_id_nxt;
        owner_valid_r <= owner_valid_nxt;
        lost_r        <= lost_nxt;
        hs_cnt_r      <= hs_cnt_nxt;
        rcv_cnt_r     <= rcv_cnt_nxt;
        drop_cnt_r    <= drop_cnt_nxt;
        flush_cnt_r   <= flush_cnt_nxt;
      end
    end
  end

  // Result flags are captured on accept; the slot is free or draining then.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_read_valid_r  <= rvalid;
      out_client_lost_r <= lost_out;
      out_close_valid_r <= close_v;
      out_close_id_r    <= close_v ? owner_id_r : '0;
    end
    if (rdata_load) begin
      out_read_data_r <= out_read_valid_r ? mem_q_r : '0;
    end
  end

  // Ring memory
  always_ff @(posedge clk) begin
    if (in_xfer && mem_we) begin
      ring_mem[wptr_r] <= in_data_in;
    end
    if (in_xfer && mem_re) begin
      mem_q_r <= ring_mem[eff_rptr];
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs. Pointers and counters hold while a result waits (nothing is
  // accepted then), so level and statistics come straight from the state.
  // ---------------------------------------------------------------------------
  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_read_valid     = out_read_valid_r;
  assign out_fill_level     = ring_dist(wptr_r, rptr_r);
  assign out_client_lost    = out_client_lost_r;
  assign out_close_valid    = out_close_valid_r;
  assign out_close_id       = out_close_id_r;
  assign out_handshakes     = hs_cnt_r;
  assign out_bytes_received = rcv_cnt_r;
  assign out_bytes_dropped  = drop_cnt_r;
  assign out_bytes_flushed  = flush_cnt_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `OBF_ASSERT_NEXT(a_accept_slot_free, in_xfer, (state_r == S_RDATA) && !out_valid_r, "accepted item did not find the result slot free")
  `OBF_ASSERT_NEXT(a_rdata_to_result, state_r == S_RDATA, out_valid_r, "read cycle did not present a result")
  `OBF_ASSERT_NOW(a_ptr_range, 1'b1, ({1'b0, wptr_r} < DEPTH_W) && ({1'b0, rptr_r} < DEPTH_W) && ({1'b0, flush_mark_r} < DEPTH_W), "ring pointer outside the memory")

endmodule

`default_nettype wire

// File: sim/owned_byte_fifo_with_flush_mark_test.sv
module owned_byte_fifo_with_flush_mark_test;
  timeunit 1ns;
  timeprecision 1ps;

  import obfifo_pkg::*;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int ID_W = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // func codes six and seven do nothing but report the state
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  // One result transfer, field for field as on the out_ ports.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic [PTR_W-1:0]  fill_level;
    logic              client_lost;
    logic              close_valid;
    logic [ID_W-1:0]   close_id;
    logic [STAT_W-1:0] handshakes;
    logic [STAT_W-1:0] bytes_received;
    logic [STAT_W-1:0] bytes_dropped;
    logic [STAT_W-1:0] bytes_flushed;
  } fifo_result_t;

  // Row of the directed table; 'typed' rows carry their result written out by hand.
  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [ID_W-1:0]   cid;
    logic [DATA_W-1:0] din;
    logic              typed;
    fifo_result_t      want;
  } dir_row_t;

  // Straight after reset every field reads zero.
  localparam fifo_result_t RES_IDLE = '0;
  // First push after reset: client 0 adopted without a close, byte stored.
  localparam fifo_result_t RES_FIRST_PUSH = '{
    read_data: 8'h00, read_valid: 1'b0, fill_level: 10'd1, client_lost: 1'b1,
    close_valid: 1'b0, close_id: 6'd0, handshakes: 32'd1, bytes_received: 32'd1,
    bytes_dropped: 32'd0, bytes_flushed: 32'd0};

  localparam dir_row_t DIRECTED_ROWS [0:22] = '{
    // empty block, no owner: nothing moves
    '{FN_POP,       6'd0,  8'h00, 1'b1, RES_IDLE},
    '{FN_QUERY,     6'd0,  8'h00, 1'b1, RES_IDLE},
    '{FN_TAKE_LOST, 6'd0,  8'h00, 1'b1, RES_IDLE},
    '{FN_CLOSE,     6'd0,  8'h00, 1'b1, RES_IDLE},   // close with no owner
    '{FN_SPARE_6,   6'd21, 8'h5a, 1'b1, RES_IDLE},
    '{FN_SPARE_7,   6'd63, 8'hff, 1'b1, RES_IDLE},
    '{FN_PUSH,      6'd0,  8'h00, 1'b1, RES_FIRST_PUSH},
    // from here on the predictor supplies the expectation
    '{FN_PUSH,      6'd0,  8'hff, 1'b0, RES_IDLE},   // owner push, no adoption
    '{FN_TAKE_LOST, 6'd0,  8'h00, 1'b0, RES_IDLE},   // reports set flag, clears it
    '{FN_POP,       6'd0,  8'h00, 1'b0, RES_IDLE},   // flush of nothing, then pop
    '{FN_PUSH,      6'd63, 8'ha5, 1'b0, RES_IDLE},   // stranger: close client 0
    '{FN_ADOPT,     6'd63, 8'h00, 1'b0, RES_IDLE},   // handshake by owner, no close
    '{FN_QUERY,     6'd0,  8'h00, 1'b0, RES_IDLE},   // flush discards two bytes
    '{FN_ADOPT,     6'd5,  8'h00, 1'b0, RES_IDLE},   // close client 63
    '{FN_CLOSE,     6'd9,  8'h00, 1'b0, RES_IDLE},   // not the owner: ignored
    '{FN_CLOSE,     6'd5,  8'h00, 1'b0, RES_IDLE},   // owner closes
    '{FN_PUSH,      6'd5,  8'h3c, 1'b0, RES_IDLE},   // adopt with no owner
    '{FN_PUSH,      6'd5,  8'hc3, 1'b0, RES_IDLE},
    '{FN_POP,       6'd0,  8'h00, 1'b0, RES_IDLE},
    '{FN_POP,       6'd0,  8'h00, 1'b0, RES_IDLE},
    '{FN_POP,       6'd0,  8'h00, 1'b0, RES_IDLE},   // empty pop
    '{FN_TAKE_LOST, 6'd0,  8'h00, 1'b0, RES_IDLE},
    '{FN_TAKE_LOST, 6'd0,  8'h00, 1'b0, RES_IDLE}    // flag already clear
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [ID_W-1:0]   in_client_id = '0;
  logic [DATA_W-1:0] in_data_in = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic              out_read_valid;
  logic [PTR_W-1:0]  out_fill_level;
  logic              out_client_lost;
  logic              out_close_valid;
  logic [ID_W-1:0]   out_close_id;
  logic [STAT_W-1:0] out_handshakes;
  logic [STAT_W-1:0] out_bytes_received;
  logic [STAT_W-1:0] out_bytes_dropped;
  logic [STAT_W-1:0] out_bytes_flushed;

  owned_byte_fifo_with_flush_mark #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_client_id       (in_client_id),
    .in_data_in         (in_data_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_read_valid     (out_read_valid),
    .out_fill_level     (out_fill_level),
    .out_client_lost    (out_client_lost),
    .out_close_valid    (out_close_valid),
    .out_close_id       (out_close_id),
    .out_handshakes     (out_handshakes),
    .out_bytes_received (out_bytes_received),
    .out_bytes_dropped  (out_bytes_dropped),
    .out_bytes_flushed  (out_bytes_flushed)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block's state. The ring is left unset: only entries written by
  // a push are ever popped, so it is never read where it holds nothing.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_ring [0:DEPTH-1];
  logic [PTR_W-1:0]  shadow_wr = '0;
  logic [PTR_W-1:0]  shadow_rd = '0;
  logic [ID_W-1:0]   shadow_owner = '0;
  logic              shadow_owned = 1'b0;
  logic              shadow_lost = 1'b0;
  logic              shadow_flush_due = 1'b0;
  logic [PTR_W-1:0]  shadow_mark = '0;
  logic [STAT_W-1:0] shadow_adoptions = '0;
  logic [STAT_W-1:0] shadow_stored = '0;
  logic [STAT_W-1:0] shadow_dropped = '0;
  logic [STAT_W-1:0] shadow_flushed = '0;

  fifo_result_t pending_results [$];   // expected results, oldest first
  int          items_sent;
  int          results_checked;
  int          errors;
  int unsigned cycle_count;

  // sender and receiver idling controls
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit rx_hold_req = 1'b0;
  bit rx_hold_done = 1'b0;
  int rx_hold_left;
  int rx_burst_left;

  // Adoption: new owner, flush mark at the write pointer, lost flag raised.
  // A close is only asked for when a different client owned the buffer.
  function automatic void adopt_client(input logic [ID_W-1:0] cid, inout fifo_result_t r);
    shadow_adoptions += 1;
    if (shadow_owned && shadow_owner != cid) begin
      r.close_valid = 1'b1;
      r.close_id    = shadow_owner;
    end
    shadow_owner     = cid;
    shadow_owned     = 1'b1;
    shadow_mark      = shadow_wr;
    shadow_flush_due = 1'b1;
    shadow_lost      = 1'b1;
  endfunction

  // Discard everything between the read pointer and the mark. The span is taken
  // modulo the ring size before it is added to the 32-bit counter.
  function automatic void apply_pending_flush();
    logic [PTR_W-1:0] span;
    if (shadow_flush_due) begin
      span             = shadow_mark - shadow_rd;
      shadow_flushed  += STAT_W'(span);
      shadow_rd        = shadow_mark;
      shadow_flush_due = 1'b0;
    end
  endfunction

  // Advances the shadow state by one accepted item and returns its result.
  function automatic fifo_result_t predict_fifo_step(input logic [FUNC_W-1:0] fn,
                                                     input logic [ID_W-1:0] cid,
                                                     input logic [DATA_W-1:0] din);
    fifo_result_t     r;
    logic [PTR_W-1:0] wr_next;
    r = '0;
    case (fn)
      FN_PUSH: begin
        if (!shadow_owned || shadow_owner != cid) adopt_client(cid, r);
        wr_next = shadow_wr + 1'b1;
        // one slot always stays free, so DEPTH-1 bytes means full
        if (wr_next != shadow_rd) begin
          shadow_ring[shadow_wr] = din;
          shadow_wr      = wr_next;
          shadow_stored += 1;
        end else begin
          shadow_dropped += 1;
        end
      end
      FN_POP: begin
        apply_pending_flush();
        if (shadow_wr != shadow_rd) begin
          r.read_data  = shadow_ring[shadow_rd];
          r.read_valid = 1'b1;
          shadow_rd    = shadow_rd + 1'b1;
        end
      end
      FN_QUERY: apply_pending_flush();
      FN_ADOPT: adopt_client(cid, r);
      FN_CLOSE: begin
        if (shadow_owned && shadow_owner == cid) begin
          shadow_owned = 1'b0;
          shadow_lost  = 1'b1;
        end
      end
      default: ;
    endcase
    // take-lost reports the flag as it was, then clears it
    r.client_lost = shadow_lost;
    if (fn == FN_TAKE_LOST) shadow_lost = 1'b0;
    r.fill_level     = shadow_wr - shadow_rd;
    r.handshakes     = shadow_adoptions;
    r.bytes_received = shadow_stored;
    r.bytes_dropped  = shadow_dropped;
    r.bytes_flushed  = shadow_flushed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge where the transfer
  // happened, possibly after an idle burst. in_valid stays high between
  // back-to-back items, so it never gets two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] cid,
                           input logic [DATA_W-1:0] din, input logic typed,
                           input fifo_result_t want);
    fifo_result_t predicted;
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_client_id <= cid;
    in_data_in   <= din;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_fifo_step(fn, cid, din);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] cid,
                      input logic [DATA_W-1:0] din);
    send_item(fn, cid, din, 1'b0, RES_IDLE);
  endtask

  // Sender goes quiet until every expected result has been transferred.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly sessions of one client pushing and the reader popping, with
  // adoptions, closes and lost-flag reads mixed in; a sixth is pure noise.
  logic [ID_W-1:0] active_client = 6'd17;

  task automatic random_items(input int count);
    int              pick;
    logic [DATA_W-1:0] dbyte;
    logic [ID_W-1:0] anyone;
    for (int i = 0; i < count; i++) begin
      pick   = $urandom_range(0, 99);
      dbyte  = DATA_W'($urandom_range(0, 255));
      anyone = ID_W'($urandom_range(0, 63));
      if (pick < 40) begin
        send(FN_PUSH, active_client, dbyte);
      end else if (pick < 58) begin
        send(FN_POP, anyone, dbyte);
      end else if (pick < 63) begin
        send(FN_QUERY, anyone, dbyte);
      end else if (pick < 68) begin
        active_client = anyone;
        send(FN_PUSH, active_client, dbyte);
      end else if (pick < 72) begin
        if ($urandom_range(0, 1) == 0) active_client = anyone;
        send(FN_ADOPT, active_client, dbyte);
      end else if (pick < 76) begin
        send(FN_CLOSE, active_client, dbyte);
      end else if (pick < 79) begin
        send(FN_CLOSE, anyone, dbyte);
      end else if (pick < 83) begin
        send(FN_TAKE_LOST, anyone, dbyte);
      end else begin
        send(FUNC_W'($urandom_range(0, 7)), anyone, dbyte);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold that it counts itself once the
  // main sequence asks for it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done <= 1'b1;
      rx_hold_left <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall    <= 1'b1;
    end else if (rx_burst_left != 0) begin
      rx_burst_left <= rx_burst_left - 1;
      out_stall     <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_burst_left <= $urandom_range(0, 8);
      out_stall     <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [STAT_W-1:0] want,
                                      input logic [STAT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, fill_level 0x%0h",
                 $time, out_fill_level);
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, out_read_data);
        check_field("read_valid", want.read_valid, out_read_valid);
        check_field("fill_level", want.fill_level, out_fill_level);
        check_field("client_lost", want.client_lost, out_client_lost);
        check_field("close_valid", want.close_valid, out_close_valid);
        check_field("close_id", want.close_id, out_close_id);
        check_field("handshakes", want.handshakes, out_handshakes);
        check_field("bytes_received", want.bytes_received, out_bytes_received);
        check_field("bytes_dropped", want.bytes_dropped, out_bytes_dropped);
        check_field("bytes_flushed", want.bytes_flushed, out_bytes_flushed);
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("owned_byte_fifo_with_flush_mark test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [PTR_W-1:0] level;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty-block corner cases, every func code, adoption rules
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].fn, DIRECTED_ROWS[i].cid, DIRECTED_ROWS[i].din,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    wait_results_drained();

    // Long receiver hold while the sender keeps offering back-to-back items;
    // the block fills its output side and must stall the input channel.
    tx_idle_en  = 1'b0;
    rx_hold_req <= 1'b1;
    random_items(40);
    tx_idle_en = 1'b1;
    wait_results_drained();

    // One client fills the ring to DEPTH-1 bytes, then a few more get dropped.
    // A flush afterwards moves the read pointer across most of the ring.
    active_client = 6'd42;
    level = shadow_wr - shadow_rd;
    while (level != PTR_W'(DEPTH - 1)) begin
      send(FN_PUSH, active_client, DATA_W'($urandom_range(0, 255)));
      level = shadow_wr - shadow_rd;
    end
    repeat (8) send(FN_PUSH, active_client, DATA_W'($urandom_range(0, 255)));
    send(FN_QUERY, 6'd0, 8'h00);
    repeat (3) send(FN_POP, 6'd0, 8'h00);
    send(FN_ADOPT, 6'd7, 8'h00);
    send(FN_PUSH, 6'd7, 8'h81);
    send(FN_QUERY, 6'd0, 8'h00);
    wait_results_drained();

    // Random part in segments; idling on some, none in the closing stretch.
    for (int seg = 0; seg < 14; seg++) begin
      tx_idle_en = (seg < 12) && (seg % 3 != 1);
      rx_idle_en <= (seg < 12) && (seg % 3 != 2);
      random_items(50);
    end

    wait_results_drained();
    repeat (20) @(posedge clk);

    $display("%0d transfers in, %0d results checked; %0d adoptions, %0d bytes stored,",
             items_sent, results_checked, shadow_adoptions, shadow_stored);
    $display("%0d dropped at full, %0d discarded by flushes, with one long output hold",
             shadow_dropped, shadow_flushed);
    if (errors == 0) begin
      $display("owned_byte_fifo_with_flush_mark test passed");
    end else begin
      $display("owned_byte_fifo_with_flush_mark test failed");
    end
    $finish;
  end

endmodule
